// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL; the clock and reset are the block's own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ORW_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("orw assertion failed");

// A condition that must hold in the cycle after a trigger.
`define ORW_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("orw assertion failed");

`endif

// ===== rtl/core/orw_pkg.sv =====
`default_nettype none
package orw_pkg;

    localparam int CNT_W     = 20;
    localparam int QDEPTH    = 8;
    localparam int QPUSH_MAX = 5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FORMAT   = 3'd1;
    localparam logic [2:0] ST_CHECKSUM = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    localparam logic [1:0] CFG_CHECK = 2'd0;
    localparam logic [1:0] CFG_PAD   = 2'd1;

    localparam logic [1:0] PAD_16 = 2'd1;
    localparam logic [1:0] PAD_32 = 2'd2;

    localparam logic [7:0] KIND_FIXUPP   = 8'h9c;
    localparam logic [7:0] KIND_FIXUPP32 = 8'h9d;
    localparam logic [7:0] KIND_MODEND   = 8'h8a;
    localparam logic [7:0] KIND_MODEND32 = 8'h8b;
    localparam logic [7:0] KIND_LINNUM   = 8'h94;
    localparam logic [7:0] KIND_SEGDEF   = 8'h98;
    localparam logic [7:0] KIND_SEGDEF32 = 8'h99;

    typedef enum logic [4:0] {
        PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_COPY, PH_SKIP,
        PH_FX_START, PH_FX_LOC2, PH_FX_DAT, PH_FX_FRAME, PH_FX_TGT,
        PH_FX_DLO, PH_FX_DHI, PH_FX_THREAD, PH_MD_TYPE, PH_MD_DONE,
        PH_LN_GRP, PH_LN_SEG, PH_LN_NLO, PH_LN_NHI, PH_LN_OLO,
        PH_LN_OHI, PH_SG_ACBP, PH_SG_ABS, PH_SG_LLO, PH_SG_LHI,
        PH_SG_NAME, PH_SG_CLASS, PH_SG_OVL, PH_SG_TAIL, PH_P32_ACBP,
        PH_P32_HEAD, PH_P32_LEN
    } t_phase;

    typedef enum logic [1:0] {
        Q_NOP, Q_WRITE, Q_RESULT, Q_READ
    } t_qop;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       record_last;
        logic [2:0] status;
    } t_rsp;

    typedef struct packed {
        logic       check_checksum;
        logic [1:0] padding_mode;
    } t_cfg;

    typedef struct packed {
        t_qop             op;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
        logic             last;
        logic [2:0]       status;
    } t_qent;

endpackage
`default_nettype wire

// ===== rtl/core/orw_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module orw_queue
    import orw_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [2:0]                  i_push_n,
    input  wire t_qent [QPUSH_MAX-1:0]       i_push_ent,
    output logic [3:0]                       o_free,
    output logic                             o_nonempty,
    output t_qent                            o_head,
    input  wire logic                        i_pop
);

    t_qent      r_ent [QDEPTH];
    logic [2:0] r_wr_ptr, n_wr_ptr;
    logic [2:0] r_rd_ptr, n_rd_ptr;
    logic [3:0] r_count, n_count;

    assign o_free     = 4'(QDEPTH) - r_count;
    assign o_nonempty = (r_count != 4'd0);
    assign o_head     = r_ent[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push_n;
        n_rd_ptr = r_rd_ptr + 3'(i_pop);
        n_count  = r_count + 4'(i_push_n) - 4'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QPUSH_MAX; i++) begin
            if (3'(i) < i_push_n) begin
                r_ent[r_wr_ptr + 3'(i)] <= i_push_ent[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `ORW_ASSERT(a_count_bound, r_count <= 4'(QDEPTH))
    `ORW_ASSERT(a_no_overflow, 4'(i_push_n) <= o_free)
    `ORW_ASSERT_NEXT(a_pop_drains, i_pop && i_push_n == 3'd0,
        r_count == $past(r_count) - 4'd1)

endmodule
`default_nettype wire

// ===== rtl/core/orw_front.sv =====
`default_nettype none
module orw_front
    import orw_pkg::*;
#(
    parameter int MAX_BODY  = 1024,
    parameter int OUT_DEPTH = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_in_valid,
    input  wire t_req                  i_in,
    output logic                       o_in_stall,
    input  wire logic [3:0]            i_q_free,
    output logic [2:0]                 o_push_n,
    output t_qent [QPUSH_MAX-1:0]      o_push_ent
);

    localparam logic [16:0]      MaxBody  = 17'(MAX_BODY);
    localparam logic [CNT_W-1:0] OutDepth = CNT_W'(OUT_DEPTH);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_kind, n_kind;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_pos, n_pos;
    logic [7:0]       r_input_sum, n_input_sum;
    logic [7:0]       r_out_sum, n_out_sum;
    logic [31:0]      r_seg, n_seg;
    logic [7:0]       r_attr, n_attr;
    logic [2:0]       r_sticky, n_sticky;
    logic             r_pending, n_pending;
    logic             r_ihp, n_ihp;
    logic [CNT_W-1:0] r_out_count, n_out_count;
    logic [CNT_W-1:0] r_drain, n_drain;

    logic             fire;
    logic [7:0]       b;
    logic [7:0]       sum_in;
    logic [7:0]       em [4];
    logic [2:0]       em_n;
    logic [2:0]       res_idx;
    logic             idx_en;
    t_phase           idx_next;
    logic [1:0]       k;
    logic [CNT_W-1:0] blen;
    logic [7:0]       kind_out;
    logic [7:0]       csum;
    logic [CNT_W-1:0] waddr;
    logic [15:0]      len_new;
    logic [31:0]      seg_tmp;
    t_qent            res;

    function automatic t_phase fixup_next(input logic [7:0] fd, input logic [7:0] kind,
                                          input logic [1:0] stage);
        t_phase ph;
        if (stage < 2'd1 && !fd[7] && fd[6:4] <= 3'd2) begin
            ph = PH_FX_FRAME;
        end else if (stage < 2'd2 && !fd[3]) begin
            ph = PH_FX_TGT;
        end else if (!fd[2]) begin
            ph = PH_FX_DLO;
        end else begin
            ph = (kind == KIND_MODEND) ? PH_MD_DONE : PH_FX_START;
        end
        return ph;
    endfunction

    function automatic logic [7:0] pad_align(input logic [7:0] a, input logic [1:0] mode);
        logic [7:0] r;
        r = a;
        if ((mode == PAD_16 || mode == PAD_32) &&
            (a[7:5] == 3'd1 || a[7:5] == 3'd2 || a[7:5] == 3'd5 || a[7:5] == 3'd6)) begin
            r = {3'd3, a[4:0]};
        end
        return r;
    endfunction

    function automatic logic [31:0] pad_length(input logic [31:0] len, input logic [1:0] mode);
        logic [31:0] r;
        case (mode)
            PAD_16:  r = (len + 32'd15) & ~32'd15;
            PAD_32:  r = (len + 32'd31) & ~32'd31;
            default: r = len;
        endcase
        return r;
    endfunction

    assign o_in_stall = (i_q_free < 4'(QPUSH_MAX));
    assign fire       = i_in_valid && !o_in_stall;
    assign b          = i_in.in_byte;
    assign sum_in     = r_input_sum + b;

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_len       = r_len;
        n_pos       = r_pos;
        n_input_sum = r_input_sum;
        n_out_sum   = r_out_sum;
        n_seg       = r_seg;
        n_attr      = r_attr;
        n_sticky    = r_sticky;
        n_pending   = r_pending;
        n_ihp       = r_ihp;
        n_out_count = r_out_count;
        n_drain     = r_drain;
        for (int i = 0; i < 4; i++) begin
            em[i] = 8'd0;
        end
        em_n      = 3'd0;
        res_idx   = 3'd0;
        idx_en    = 1'b0;
        idx_next  = PH_TYPE;
        k         = 2'd0;
        blen      = r_out_count - CNT_W'(2);
        kind_out  = r_kind;
        csum      = 8'd0;
        waddr     = '0;
        len_new   = {b, r_len[7:0]};
        seg_tmp   = r_seg;
        res       = '0;
        res.op    = Q_RESULT;
        o_push_ent = '0;
        o_push_n   = 3'd0;

        if (fire) begin
            if (i_in.req_type) begin
                if (r_pending && r_drain < r_out_count) begin
                    res.op   = Q_READ;
                    res.addr = r_drain;
                    res.last = (r_drain + CNT_W'(1) == r_out_count);
                    n_drain  = r_drain + CNT_W'(1);
                    if (n_drain >= r_out_count) begin
                        n_pending = 1'b0;
                    end
                end else begin
                    n_pending = 1'b0;
                end
                res.status = r_sticky;
            end else if (r_sticky != ST_OK) begin
                res.status = r_sticky;
            end else if (r_pending) begin
                res.status = ST_BUSY;
            end else begin
                n_input_sum = sum_in;
                unique case (r_phase)
                    PH_TYPE: begin
                        n_kind      = b;
                        n_input_sum = b;
                        n_out_count = CNT_W'(3);
                        n_out_sum   = 8'd0;
                        n_ihp       = 1'b0;
                        n_phase     = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_len   = {8'd0, b};
                        n_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_len = len_new;
                        if (len_new == 16'd0) begin
                            n_sticky = ST_FORMAT;
                        end else if ({1'b0, len_new} - 17'd1 > MaxBody) begin
                            n_sticky = ST_TOO_LONG;
                        end else begin
                            n_pos = 16'd0;
                            unique case (r_kind)
                                KIND_FIXUPP:   n_phase = PH_FX_START;
                                KIND_MODEND:   n_phase = PH_MD_TYPE;
                                KIND_LINNUM:   n_phase = PH_LN_GRP;
                                KIND_SEGDEF:   n_phase = PH_SG_ACBP;
                                KIND_SEGDEF32: n_phase = (i_cfg.padding_mode == PAD_16 ||
                                    i_cfg.padding_mode == PAD_32) ? PH_P32_ACBP : PH_COPY;
                                default:       n_phase = PH_COPY;
                            endcase
                        end
                    end
                    default: begin
                        if ({1'b0, r_pos} + 17'd1 >= {1'b0, r_len}) begin
                            // Checksum byte: close the record and fill in its header.
                            if (i_cfg.check_checksum && sum_in != 8'd0) begin
                                n_sticky = ST_CHECKSUM;
                            end else if (!(r_phase == PH_COPY || r_phase == PH_FX_START ||
                                           r_phase == PH_MD_DONE || r_phase == PH_LN_NLO ||
                                           r_phase == PH_SG_TAIL)) begin
                                n_sticky = ST_FORMAT;
                            end else if (r_out_count + CNT_W'(1) > OutDepth ||
                                         blen > CNT_W'(16'hffff)) begin
                                n_sticky = ST_TOO_LONG;
                            end else begin
                                if (r_kind == KIND_FIXUPP || r_kind == KIND_MODEND ||
                                    r_kind == KIND_LINNUM || r_kind == KIND_SEGDEF) begin
                                    kind_out = r_kind + 8'd1;
                                end
                                csum = 8'd0 - (kind_out + blen[7:0] + blen[15:8] + r_out_sum);
                                o_push_ent[0] = '{op: Q_WRITE, addr: CNT_W'(0),
                                                  data: kind_out, last: 1'b0, status: ST_OK};
                                o_push_ent[1] = '{op: Q_WRITE, addr: CNT_W'(1),
                                                  data: blen[7:0], last: 1'b0, status: ST_OK};
                                o_push_ent[2] = '{op: Q_WRITE, addr: CNT_W'(2),
                                                  data: blen[15:8], last: 1'b0, status: ST_OK};
                                o_push_ent[3] = '{op: Q_WRITE, addr: r_out_count,
                                                  data: csum, last: 1'b0, status: ST_OK};
                                res_idx     = 3'd4;
                                n_out_count = r_out_count + CNT_W'(1);
                                n_pending   = 1'b1;
                                n_drain     = '0;
                                n_phase     = PH_TYPE;
                            end
                        end else begin
                            n_pos = r_pos + 16'd1;
                            case (r_phase)
                                PH_COPY: begin
                                    em[0] = b;
                                    em_n  = 3'd1;
                                end
                                PH_FX_START: begin
                                    em[0]   = b;
                                    em_n    = 3'd1;
                                    n_phase = b[7] ? PH_FX_LOC2 : PH_FX_THREAD;
                                end
                                PH_FX_LOC2: begin
                                    em[0]   = b;
                                    em_n    = 3'd1;
                                    n_phase = PH_FX_DAT;
                                end
                                PH_FX_DAT: begin
                                    em[0]   = b;
                                    em_n    = 3'd1;
                                    n_attr  = b;
                                    n_phase = fixup_next(b, r_kind, 2'd0);
                                end
                                PH_FX_THREAD: begin
                                    idx_en   = 1'b1;
                                    idx_next = PH_FX_START;
                                end
                                PH_FX_FRAME: begin
                                    idx_en   = 1'b1;
                                    idx_next = fixup_next(r_attr, r_kind, 2'd1);
                                end
                                PH_FX_TGT: begin
                                    idx_en   = 1'b1;
                                    idx_next = fixup_next(r_attr, r_kind, 2'd2);
                                end
                                PH_FX_DLO, PH_LN_OLO: begin
                                    n_seg   = {24'd0, b};
                                    n_phase = (r_phase == PH_FX_DLO) ? PH_FX_DHI : PH_LN_OHI;
                                end
                                PH_FX_DHI, PH_LN_OHI: begin
                                    seg_tmp = {r_seg[31:16], b, r_seg[7:0]};
                                    n_seg   = seg_tmp;
                                    em[0]   = seg_tmp[7:0];
                                    em[1]   = seg_tmp[15:8];
                                    em[2]   = seg_tmp[23:16];
                                    em[3]   = seg_tmp[31:24];
                                    em_n    = 3'd4;
                                    if (r_phase == PH_LN_OHI) begin
                                        n_phase = PH_LN_NLO;
                                    end else begin
                                        n_phase = (r_kind == KIND_MODEND) ? PH_MD_DONE
                                                                          : PH_FX_START;
                                    end
                                end
                                PH_MD_TYPE: begin
                                    em[0]   = b;
                                    em_n    = 3'd1;
                                    n_phase = b[0] ? PH_FX_DAT : PH_MD_DONE;
                                end
                                PH_MD_DONE: n_phase = PH_SKIP;
                                PH_LN_GRP: begin
                                    idx_en   = 1'b1;
                                    idx_next = PH_LN_SEG;
                                end
                                PH_LN_SEG: begin
                                    idx_en   = 1'b1;
                                    idx_next = PH_LN_NLO;
                                end
                                PH_LN_NLO: begin
                                    em[0]   = b;
                                    em_n    = 3'd1;
                                    n_phase = PH_LN_NHI;
                                end
                                PH_LN_NHI: begin
                                    em[0]   = b;
                                    em_n    = 3'd1;
                                    n_phase = PH_LN_OLO;
                                end
                                PH_SG_ACBP: begin
                                    n_attr  = b;
                                    em[0]   = pad_align(b & 8'hfd, i_cfg.padding_mode);
                                    em_n    = 3'd1;
                                    n_phase = (b[7:5] == 3'd0) ? PH_SG_ABS : PH_SG_LLO;
                                end
                                PH_SG_ABS, PH_P32_HEAD: begin
                                    em[0] = b;
                                    em_n  = 3'd1;
                                    if (r_pos >= 16'd3) begin
                                        n_phase = (r_phase == PH_SG_ABS) ? PH_SG_LLO
                                                                         : PH_P32_LEN;
                                    end
                                end
                                PH_SG_LLO: begin
                                    n_seg   = {24'd0, b};
                                    n_phase = PH_SG_LHI;
                                end
                                PH_SG_LHI: begin
                                    seg_tmp = {r_seg[31:16], b, r_seg[7:0]};
                                    if (r_attr[1]) begin
                                        seg_tmp = 32'h0001_0000;
                                    end
                                    n_seg   = seg_tmp;
                                    seg_tmp = pad_length(seg_tmp, i_cfg.padding_mode);
                                    em[0]   = seg_tmp[7:0];
                                    em[1]   = seg_tmp[15:8];
                                    em[2]   = seg_tmp[23:16];
                                    em[3]   = seg_tmp[31:24];
                                    em_n    = 3'd4;
                                    n_phase = PH_SG_NAME;
                                end
                                PH_SG_NAME: begin
                                    idx_en   = 1'b1;
                                    idx_next = PH_SG_CLASS;
                                end
                                PH_SG_CLASS: begin
                                    idx_en   = 1'b1;
                                    idx_next = PH_SG_OVL;
                                end
                                PH_SG_OVL: begin
                                    idx_en   = 1'b1;
                                    idx_next = PH_SG_TAIL;
                                end
                                PH_P32_ACBP: begin
                                    n_attr  = b;
                                    n_seg   = 32'd0;
                                    em[0]   = pad_align(b, i_cfg.padding_mode);
                                    em_n    = 3'd1;
                                    n_phase = (b[7:5] == 3'd0) ? PH_P32_HEAD : PH_P32_LEN;
                                end
                                PH_P32_LEN: begin
                                    k = r_pos[1:0] - ((r_attr[7:5] == 3'd0) ? 2'd0 : 2'd1);
                                    case (k)
                                        2'd0:    seg_tmp = {r_seg[31:8], b};
                                        2'd1:    seg_tmp = {r_seg[31:16], b, r_seg[7:0]};
                                        2'd2:    seg_tmp = {r_seg[31:24], b, r_seg[15:0]};
                                        default: seg_tmp = {b, r_seg[23:0]};
                                    endcase
                                    n_seg = seg_tmp;
                                    if (k == 2'd3) begin
                                        seg_tmp = pad_length(seg_tmp, i_cfg.padding_mode);
                                        em[0]   = seg_tmp[7:0];
                                        em[1]   = seg_tmp[15:8];
                                        em[2]   = seg_tmp[23:16];
                                        em[3]   = seg_tmp[31:24];
                                        em_n    = 3'd4;
                                        n_phase = PH_COPY;
                                    end
                                end
                                default: ;
                            endcase
                            // An index is one byte, or two when the first has its top bit set.
                            if (idx_en) begin
                                em[0] = b;
                                em_n  = 3'd1;
                                if (r_ihp) begin
                                    n_ihp   = 1'b0;
                                    n_phase = idx_next;
                                end else if (b[7]) begin
                                    n_ihp = 1'b1;
                                end else begin
                                    n_phase = idx_next;
                                end
                            end
                            for (int i = 0; i < 4; i++) begin
                                if (3'(i) < em_n) begin
                                    waddr = r_out_count + CNT_W'(i);
                                    o_push_ent[i].op   = (waddr < OutDepth) ? Q_WRITE : Q_NOP;
                                    o_push_ent[i].addr = waddr;
                                    o_push_ent[i].data = em[i];
                                    n_out_sum          = n_out_sum + em[i];
                                end
                            end
                            n_out_count = r_out_count + CNT_W'(em_n);
                            res_idx     = em_n;
                        end
                    end
                endcase
                if (i_in.end_of_input && n_sticky == ST_OK && n_phase != PH_TYPE) begin
                    n_sticky = ST_FORMAT;
                end
                res.status = n_sticky;
            end
            o_push_ent[res_idx] = res;
            o_push_n            = res_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_kind      <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_input_sum <= '0;
            r_out_sum   <= '0;
            r_seg       <= '0;
            r_attr      <= '0;
            r_sticky    <= ST_OK;
            r_pending   <= 1'b0;
            r_ihp       <= 1'b0;
            r_out_count <= '0;
            r_drain     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_input_sum <= n_input_sum;
            r_out_sum   <= n_out_sum;
            r_seg       <= n_seg;
            r_attr      <= n_attr;
            r_sticky    <= n_sticky;
            r_pending   <= n_pending;
            r_ihp       <= n_ihp;
            r_out_count <= n_out_count;
            r_drain     <= n_drain;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/orw_back.sv =====
`default_nettype none
module orw_back
    import orw_pkg::*;
#(
    parameter int OUT_DEPTH = 2048
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_nonempty,
    input  wire t_qent  i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    output t_rsp        o_out,
    input  wire logic   i_out_stall
);

    localparam int AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

    logic [7:0] r_mem [OUT_DEPTH];
    logic [7:0] r_rd_data;
    logic       r_valid, n_valid;
    logic       r_is_read, n_is_read;
    logic       r_last, n_last;
    logic [2:0] r_status, n_status;
    logic       slot_free;
    logic       do_write;
    logic       do_read;

    assign slot_free = !r_valid || !i_out_stall;

    always_comb begin
        o_pop     = 1'b0;
        do_write  = 1'b0;
        do_read   = 1'b0;
        n_valid   = r_valid && i_out_stall;
        n_is_read = r_is_read;
        n_last    = r_last;
        n_status  = r_status;
        if (i_q_nonempty) begin
            unique case (i_head.op)
                Q_NOP: o_pop = 1'b1;
                Q_WRITE: begin
                    o_pop    = 1'b1;
                    do_write = 1'b1;
                end
                Q_RESULT, Q_READ: begin
                    if (slot_free) begin
                        o_pop     = 1'b1;
                        do_read   = (i_head.op == Q_READ);
                        n_valid   = 1'b1;
                        n_is_read = (i_head.op == Q_READ);
                        n_last    = i_head.last;
                        n_status  = i_head.status;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[i_head.addr[AW-1:0]] <= i_head.data;
        end
        if (do_read) begin
            r_rd_data <= r_mem[i_head.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_is_read <= 1'b0;
            r_last    <= 1'b0;
            r_status  <= ST_OK;
        end else begin
            r_valid   <= n_valid;
            r_is_read <= n_is_read;
            r_last    <= n_last;
            r_status  <= n_status;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_out.out_byte    = r_is_read ? r_rd_data : 8'd0;
    assign o_out.out_valid   = r_is_read;
    assign o_out.record_last = r_last;
    assign o_out.status      = r_status;

endmodule
`default_nettype wire

// ===== rtl/core/object_record_widener.sv =====
`default_nettype none
// Rewrites a stream of 16-bit object records into their 32-bit forms. Each transaction is a
// push of one source byte or a pull of one output byte, and each gives exactly one result.
// A front parser takes one transaction per cycle when not stalled and queues up to five
// operations (body writes into the record store, the header and checksum fill on the last
// byte of a record, and the result itself); a back unit retires one queued operation per
// cycle but holds a result while its output stalls. A push queues one to five operations
// depending on how many bytes it writes, and a pull one. The front stalls while fewer than
// five queue slots are free. The record store is a single-port byte memory of OUT_DEPTH
// entries; it needs no clearing after reset because only written entries are ever drained.
// Configuration writes are always accepted and should be made only while the block is idle.
module object_record_widener
    import orw_pkg::*;
#(
    parameter int MAX_BODY  = 1024,
    parameter int OUT_DEPTH = 2048
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_req       i_in,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output t_rsp            o_out,
    input  wire logic       i_out_stall,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    logic [3:0]            q_free;
    logic [2:0]            push_n;
    t_qent [QPUSH_MAX-1:0] push_ent;
    logic                  q_nonempty;
    t_qent                 q_head;
    logic                  q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CHECK: r_cfg.check_checksum <= i_cfg_data[0];
                CFG_PAD:   r_cfg.padding_mode   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    orw_front #(
        .MAX_BODY  (MAX_BODY),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_q_free   (q_free),
        .o_push_n   (push_n),
        .o_push_ent (push_ent)
    );

    orw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_push_ent (push_ent),
        .o_free     (q_free),
        .o_nonempty (q_nonempty),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    orw_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_stall  (i_out_stall)
    );

endmodule
`default_nettype wire
